// ===== rtl/core/i2cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types, codes and result builders shared by the I2C register sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cseq_pkg;

    localparam logic [7:0] MAX_COUNT = 8'd255;
    localparam int         NUM_RES   = 3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DEV,
        PH_REG,
        PH_WREQ,
        PH_WDATA,
        PH_DEVR,
        PH_RDATA
    } phase_t;

    typedef enum logic [1:0] {
        REQ_WRITE,
        REQ_READ,
        REQ_DONE,
        REQ_DATA
    } req_t;

    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_WREQ,
        KIND_RBYTE,
        KIND_DONE
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DEV_NACK  = 3'd1;
    localparam logic [2:0] ST_REG_NACK  = 3'd2;
    localparam logic [2:0] ST_DATA_NACK = 3'd3;
    localparam logic [2:0] ST_ARB_LOST  = 3'd4;

    typedef struct packed {
        req_t       req_type;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       got_nack;
        logic       arb_lost;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic       cmd_start;
        logic       cmd_write;
        logic       cmd_read;
        logic       cmd_nack;
        logic       cmd_stop;
        logic [7:0] byte_value;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0]                count;
        result_t [NUM_RES-1:0]     res;
    } bundle_t;

    function automatic result_t res_cmd(input logic st, input logic wr, input logic rd,
                                        input logic nk, input logic sp,
                                        input logic [7:0] val);
        result_t r;
        r            = '0;
        r.kind       = KIND_CMD;
        r.cmd_start  = st;
        r.cmd_write  = wr;
        r.cmd_read   = rd;
        r.cmd_nack   = nk;
        r.cmd_stop   = sp;
        r.byte_value = val;
        return r;
    endfunction

    function automatic result_t res_other(input kind_t kind, input logic [7:0] val,
                                          input logic [2:0] st);
        result_t r;
        r            = '0;
        r.kind       = kind;
        r.byte_value = val;
        r.status     = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2cseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cseq_ctrl
// Transaction state machine: turns one event into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cseq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire i2cseq_pkg::item_t   item,
    output i2cseq_pkg::bundle_t      bundle
);

    i2cseq_pkg::phase_t phase_reg, phase_next;
    logic               is_read_reg, is_read_next;
    logic [7:0]         saved_dev_reg, saved_dev_next;
    logic [7:0]         saved_reg_reg, saved_reg_next;
    logic [7:0]         remaining_reg, remaining_next;

    logic [7:0] rem_after;
    logic [2:0] end_status;

    assign rem_after  = (remaining_reg == 8'd0) ? 8'd0 : remaining_reg - 8'd1;
    assign end_status = item.arb_lost ? i2cseq_pkg::ST_ARB_LOST : i2cseq_pkg::ST_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cseq_pkg::PH_IDLE;
            is_read_reg   <= 1'b0;
            saved_dev_reg <= 8'd0;
            saved_reg_reg <= 8'd0;
            remaining_reg <= 8'd0;
        end
        else if (go)
        begin
            phase_reg     <= phase_next;
            is_read_reg   <= is_read_next;
            saved_dev_reg <= saved_dev_next;
            saved_reg_reg <= saved_reg_next;
            remaining_reg <= remaining_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        is_read_next   = is_read_reg;
        saved_dev_next = saved_dev_reg;
        saved_reg_next = saved_reg_reg;
        remaining_next = remaining_reg;
        unique case (item.req_type) inside
            i2cseq_pkg::REQ_WRITE, i2cseq_pkg::REQ_READ:
            begin
                if (phase_reg == i2cseq_pkg::PH_IDLE)
                begin
                    is_read_next   = (item.req_type == i2cseq_pkg::REQ_READ);
                    saved_dev_next = item.device_addr;
                    saved_reg_next = item.reg_addr;
                    remaining_next = (item.byte_count > i2cseq_pkg::MAX_COUNT) ?
                                     i2cseq_pkg::MAX_COUNT : item.byte_count;
                    phase_next     = i2cseq_pkg::PH_DEV;
                end
            end
            i2cseq_pkg::REQ_DATA:
            begin
                if (phase_reg == i2cseq_pkg::PH_WREQ)
                    phase_next = i2cseq_pkg::PH_WDATA;
            end
            default:
            begin
                unique case (phase_reg)
                    i2cseq_pkg::PH_DEV:
                        phase_next = item.got_nack ? i2cseq_pkg::PH_IDLE
                                                   : i2cseq_pkg::PH_REG;
                    i2cseq_pkg::PH_REG:
                    begin
                        if (item.got_nack)
                            phase_next = i2cseq_pkg::PH_IDLE;
                        else if (is_read_reg)
                            phase_next = i2cseq_pkg::PH_DEVR;
                        else if (remaining_reg == 8'd0)
                            phase_next = i2cseq_pkg::PH_IDLE;
                        else
                            phase_next = i2cseq_pkg::PH_WREQ;
                    end
                    i2cseq_pkg::PH_WDATA:
                    begin
                        if (item.got_nack)
                            phase_next = i2cseq_pkg::PH_IDLE;
                        else
                        begin
                            remaining_next = remaining_reg - 8'd1;
                            phase_next     = (remaining_reg == 8'd1) ? i2cseq_pkg::PH_IDLE
                                                                     : i2cseq_pkg::PH_WREQ;
                        end
                    end
                    i2cseq_pkg::PH_DEVR:
                    begin
                        if (item.got_nack || remaining_reg == 8'd0)
                            phase_next = i2cseq_pkg::PH_IDLE;
                        else
                            phase_next = i2cseq_pkg::PH_RDATA;
                    end
                    i2cseq_pkg::PH_RDATA:
                    begin
                        remaining_next = rem_after;
                        phase_next     = (rem_after == 8'd0) ? i2cseq_pkg::PH_IDLE
                                                             : i2cseq_pkg::PH_RDATA;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        endcase
    end

    // results
    always_comb
    begin
        bundle = '0;
        unique case (item.req_type) inside
            i2cseq_pkg::REQ_WRITE, i2cseq_pkg::REQ_READ:
            begin
                if (phase_reg == i2cseq_pkg::PH_IDLE)
                begin
                    bundle.count  = 2'd1;
                    bundle.res[0] = i2cseq_pkg::res_cmd(1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                                        {item.device_addr[7:1], 1'b0});
                end
            end
            i2cseq_pkg::REQ_DATA:
            begin
                if (phase_reg == i2cseq_pkg::PH_WREQ)
                begin
                    bundle.count  = 2'd1;
                    bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                                        item.data_byte);
                end
            end
            default:
            begin
                // a finish is a STOP command followed by the done result
                unique case (phase_reg)
                    i2cseq_pkg::PH_DEV:
                    begin
                        if (item.got_nack)
                        begin
                            bundle.count  = 2'd2;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b0, 1'b0,
                                                                1'b1, 8'd0);
                            bundle.res[1] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_DONE,
                                                8'd0, i2cseq_pkg::ST_DEV_NACK);
                        end
                        else
                        begin
                            bundle.count  = 2'd1;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b1, 1'b0, 1'b0,
                                                                1'b0, saved_reg_reg);
                        end
                    end
                    i2cseq_pkg::PH_REG:
                    begin
                        if (item.got_nack || (!is_read_reg && remaining_reg == 8'd0))
                        begin
                            bundle.count  = 2'd2;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b0, 1'b0,
                                                                1'b1, 8'd0);
                            bundle.res[1] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_DONE,
                                                8'd0, item.got_nack ?
                                                i2cseq_pkg::ST_REG_NACK : end_status);
                        end
                        else if (is_read_reg)
                        begin
                            bundle.count  = 2'd1;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b1, 1'b1, 1'b0, 1'b0,
                                                1'b0, {saved_dev_reg[7:1], 1'b1});
                        end
                        else
                        begin
                            bundle.count  = 2'd1;
                            bundle.res[0] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_WREQ,
                                                8'd0, i2cseq_pkg::ST_OK);
                        end
                    end
                    i2cseq_pkg::PH_WDATA:
                    begin
                        if (item.got_nack || remaining_reg == 8'd1)
                        begin
                            bundle.count  = 2'd2;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b0, 1'b0,
                                                                1'b1, 8'd0);
                            bundle.res[1] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_DONE,
                                                8'd0, item.got_nack ?
                                                i2cseq_pkg::ST_DATA_NACK : end_status);
                        end
                        else
                        begin
                            bundle.count  = 2'd1;
                            bundle.res[0] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_WREQ,
                                                8'd0, i2cseq_pkg::ST_OK);
                        end
                    end
                    i2cseq_pkg::PH_DEVR:
                    begin
                        if (item.got_nack || remaining_reg == 8'd0)
                        begin
                            bundle.count  = 2'd2;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b0, 1'b0,
                                                                1'b1, 8'd0);
                            bundle.res[1] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_DONE,
                                                8'd0, item.got_nack ?
                                                i2cseq_pkg::ST_DEV_NACK : end_status);
                        end
                        else
                        begin
                            bundle.count  = 2'd1;
                            bundle.res[0] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b1,
                                                remaining_reg == 8'd1, 1'b0, 8'd0);
                        end
                    end
                    i2cseq_pkg::PH_RDATA:
                    begin
                        // got_nack is ignored on read completions
                        bundle.res[0] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_RBYTE,
                                            item.rx_byte, i2cseq_pkg::ST_OK);
                        if (rem_after == 8'd0)
                        begin
                            bundle.count  = 2'd3;
                            bundle.res[1] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b0, 1'b0,
                                                                1'b1, 8'd0);
                            bundle.res[2] = i2cseq_pkg::res_other(i2cseq_pkg::KIND_DONE,
                                                8'd0, end_status);
                        end
                        else
                        begin
                            bundle.count  = 2'd2;
                            bundle.res[1] = i2cseq_pkg::res_cmd(1'b0, 1'b0, 1'b1,
                                                rem_after == 8'd1, 1'b0, 8'd0);
                        end
                    end
                    default:
                        bundle.count = 2'd0;
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2cseq_out.sv =====
// ----------------------------------------------------------------------------
// i2cseq_out
// Result buffer: holds one event's results and hands them out one per cycle while ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cseq_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire i2cseq_pkg::bundle_t bundle,
    output logic                     free,
    output logic                     valid,
    input  wire logic                ready,
    output i2cseq_pkg::result_t      result,
    output logic                     last
);

    logic                                      valid_reg;
    logic [1:0]                                idx_reg;
    logic [1:0]                                count_reg;
    i2cseq_pkg::result_t [i2cseq_pkg::NUM_RES-1:0] res_reg;

    logic take;
    logic take_last;

    assign valid     = valid_reg;
    assign last      = (idx_reg == count_reg - 2'd1);
    assign result    = res_reg[idx_reg];
    assign take      = valid_reg && ready;
    assign take_last = take && last;
    assign free      = !valid_reg || take_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            count_reg <= 2'd0;
        end
        else if (load && bundle.count != 2'd0)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
            count_reg <= bundle.count;
        end
        else if (take_last)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bundle.count != 2'd0)
            res_reg <= bundle.res;
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_register_transaction_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_core
// Register-addressed I2C write/read sequencer above a byte-level master.
// ----------------------------------------------------------------------------
// Events (host begin write/read, engine completion, host write byte) enter on
// the slave stream, one transaction per cycle while s_axis_tready is high, into
// an input register; the state machine decides each event from that register
// and yields zero to three results, which leave on the master stream one per
// cycle while m_axis_tready is high, from a result buffer. An event waits in
// the input register until the buffer is free; the result buffer's single
// output port sets the sustained rate. Events that cause no result (begin
// while busy, stray completions or data bytes) are absorbed silently. The last
// result of each event carries tlast.
`default_nettype none

module i2c_register_transaction_sequencer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // device_addr[7:0], reg_addr[15:8], byte_count[23:16], data_byte[31:24],
    // got_nack[32], arb_lost[33], rx_byte[41:34], zero pad [47:42]
    input  wire logic [47:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cmd_start[0], cmd_write[1], cmd_read[2], cmd_nack[3], cmd_stop[4],
    // byte_value[12:5], status[15:13]
    output logic [15:0]      m_axis_tdata,
    // out_kind[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    logic                in_valid_reg;
    i2cseq_pkg::item_t   in_item_reg;
    i2cseq_pkg::item_t   in_item;
    i2cseq_pkg::bundle_t bundle;
    i2cseq_pkg::result_t result;
    logic                out_free;
    logic                go;

    assign in_item.req_type    = i2cseq_pkg::req_t'(s_axis_tuser);
    assign in_item.device_addr = s_axis_tdata[7:0];
    assign in_item.reg_addr    = s_axis_tdata[15:8];
    assign in_item.byte_count  = s_axis_tdata[23:16];
    assign in_item.data_byte   = s_axis_tdata[31:24];
    assign in_item.got_nack    = s_axis_tdata[32];
    assign in_item.arb_lost    = s_axis_tdata[33];
    assign in_item.rx_byte     = s_axis_tdata[41:34];

    assign go            = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
    end

    i2cseq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    i2cseq_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (go),
        .bundle (bundle),
        .free   (out_free),
        .valid  (m_axis_tvalid),
        .ready  (m_axis_tready),
        .result (result),
        .last   (m_axis_tlast)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {result.status, result.byte_value, result.cmd_stop,
                           result.cmd_nack, result.cmd_read, result.cmd_write,
                           result.cmd_start};

endmodule

`default_nettype wire

// ===== rtl/core/i2cseq_checker.sv =====
// ----------------------------------------------------------------------------
// i2cseq_checker
// Port-level checks on the sequencer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cseq_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast
);

    // a done result always closes the event's results
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == i2cseq_pkg::KIND_DONE |-> m_axis_tlast)
        else $error("done result without tlast");

    // command bits only on bus commands
    a_cmd_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != i2cseq_pkg::KIND_CMD |-> m_axis_tdata[4:0] == 5'd0)
        else $error("command bits on non-command result");

    // status only in done results, and in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == i2cseq_pkg::KIND_DONE ||
                           m_axis_tdata[15:13] == 3'd0) && m_axis_tdata[15:13] <= 3'd4)
        else $error("bad status field");

    // a STOP command is always followed by its done result
    a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == i2cseq_pkg::KIND_CMD &&
        m_axis_tdata[4] |=> m_axis_tvalid && m_axis_tuser == i2cseq_pkg::KIND_DONE)
        else $error("stop not followed by done");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_register_transaction_sequencer_core i2cseq_checker u_i2cseq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// The testbench plays both the host and the byte engine around the I2C
// register sequencer. An event-level predictor tracks the transaction phase
// and queues the expected bus commands, write byte requests, read bytes and
// done results. Each result leaving the master stream is compared, field by
// field, with the oldest queued one. Directed tests come first, then a
// random walk of mostly well-formed host and engine events. Both streams
// idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;
    import i2cseq_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_EVENTS = 85;

    typedef struct {
        kind_t      kind;
        logic       cmd_start;
        logic       cmd_write;
        logic       cmd_read;
        logic       cmd_nack;
        logic       cmd_stop;
        logic [7:0] byte_value;
        logic [2:0] status;
        logic       last;
    } bus_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predicted sequencer state
    phase_t      seq_phase  = PH_IDLE;
    logic        rd_mode    = 1'b0;
    logic [7:0]  dev_byte   = '0;
    logic [7:0]  reg_byte   = '0;
    logic [7:0]  bytes_left = '0;

    bus_result_t pending_results[$];
    int          errors        = 0;
    int          last_produced = 0;
    bit          steady        = 1'b0;
    int unsigned cycles        = 0;

    i2c_register_transaction_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void push_result(input kind_t kind, input logic st, input logic wr,
                                        input logic rd, input logic nk, input logic sp,
                                        input logic [7:0] val, input logic [2:0] status);
        bus_result_t r;
        r.kind       = kind;
        r.cmd_start  = st;
        r.cmd_write  = wr;
        r.cmd_read   = rd;
        r.cmd_nack   = nk;
        r.cmd_stop   = sp;
        r.byte_value = val;
        r.status     = status;
        r.last       = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void close_transaction(input logic [2:0] status);
        push_result(KIND_CMD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, ST_OK);
        push_result(KIND_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, status);
        seq_phase = PH_IDLE;
    endfunction

    function automatic void issue_read();
        // NACK only on the final byte of the read
        push_result(KIND_CMD, 1'b0, 1'b0, 1'b1, bytes_left == 8'd1, 1'b0, 8'h00, ST_OK);
        seq_phase = PH_RDATA;
    endfunction

    function automatic int predict_event(input item_t ev);
        int          size_on_entry;
        logic [2:0]  end_status;
        bus_result_t tail;
        size_on_entry = pending_results.size();
        end_status    = ev.arb_lost ? ST_ARB_LOST : ST_OK;
        case (ev.req_type)
            REQ_WRITE, REQ_READ:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    rd_mode    = (ev.req_type == REQ_READ);
                    dev_byte   = ev.device_addr;
                    reg_byte   = ev.reg_addr;
                    bytes_left = (ev.byte_count > MAX_COUNT) ? MAX_COUNT : ev.byte_count;
                    push_result(KIND_CMD, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                {ev.device_addr[7:1], 1'b0}, ST_OK);
                    seq_phase = PH_DEV;
                end
            end
            REQ_DATA:
            begin
                if (seq_phase == PH_WREQ)
                begin
                    push_result(KIND_CMD, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ev.data_byte, ST_OK);
                    seq_phase = PH_WDATA;
                end
            end
            REQ_DONE:
            begin
                case (seq_phase)
                    PH_DEV:
                    begin
                        if (ev.got_nack)
                            close_transaction(ST_DEV_NACK);
                        else
                        begin
                            push_result(KIND_CMD, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, reg_byte,
                                        ST_OK);
                            seq_phase = PH_REG;
                        end
                    end
                    PH_REG:
                    begin
                        if (ev.got_nack)
                            close_transaction(ST_REG_NACK);
                        else if (rd_mode)
                        begin
                            push_result(KIND_CMD, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                        {dev_byte[7:1], 1'b1}, ST_OK);
                            seq_phase = PH_DEVR;
                        end
                        else if (bytes_left == 8'd0)
                            close_transaction(end_status);
                        else
                        begin
                            push_result(KIND_WREQ, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,
                                        ST_OK);
                            seq_phase = PH_WREQ;
                        end
                    end
                    PH_WDATA:
                    begin
                        if (ev.got_nack)
                            close_transaction(ST_DATA_NACK);
                        else
                        begin
                            bytes_left = bytes_left - 8'd1;
                            if (bytes_left == 8'd0)
                                close_transaction(end_status);
                            else
                            begin
                                push_result(KIND_WREQ, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,
                                            ST_OK);
                                seq_phase = PH_WREQ;
                            end
                        end
                    end
                    PH_DEVR:
                    begin
                        if (ev.got_nack)
                            close_transaction(ST_DEV_NACK);
                        else if (bytes_left == 8'd0)
                            close_transaction(end_status);
                        else
                            issue_read();
                    end
                    PH_RDATA:
                    begin
                        // got_nack has no meaning on a read completion
                        push_result(KIND_RBYTE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ev.rx_byte,
                                    ST_OK);
                        if (bytes_left > 8'd0)
                            bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 8'd0)
                            close_transaction(end_status);
                        else
                            issue_read();
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        if (pending_results.size() > size_on_entry)
        begin
            tail      = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
        return pending_results.size() - size_on_entry;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic item_t make_event(input req_t req, input logic [7:0] dev,
                                         input logic [7:0] regad, input logic [7:0] cnt,
                                         input logic [7:0] wbyte, input logic nack,
                                         input logic arb, input logic [7:0] rx);
        item_t ev;
        ev.req_type    = req;
        ev.device_addr = dev;
        ev.reg_addr    = regad;
        ev.byte_count  = cnt;
        ev.data_byte   = wbyte;
        ev.got_nack    = nack;
        ev.arb_lost    = arb;
        ev.rx_byte     = rx;
        return ev;
    endfunction

    function automatic item_t random_event();
        return make_event(req_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          8'($urandom));
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_event(input item_t ev);
        if (!steady && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.req_type;
        s_axis_tdata  <= {6'd0, ev.rx_byte, ev.arb_lost, ev.got_nack, ev.data_byte,
                          ev.byte_count, ev.reg_addr, ev.device_addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        last_produced = predict_event(ev);
    endtask

    task automatic test_write_extremes();
        send_event(make_event(REQ_WRITE, 8'hFF, 8'h00, 8'd1, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        // begin while a transaction is running is dropped
        send_event(make_event(REQ_READ, 8'h55, 8'hAA, 8'd3, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DATA, 8'h00, 8'h00, 8'd0, 8'hFF, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_read_ack_nack();
        send_event(make_event(REQ_READ, 8'h00, 8'hFF, 8'd2, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'hFF));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic test_zero_count_write();
        send_event(make_event(REQ_WRITE, 8'hA5, 8'h5A, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_full_count_aborts();
        // repeated start refused
        send_event(make_event(REQ_READ, 8'h3C, 8'hC3, 8'd255, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b1, 1'b0, 8'h00));
        // first data byte refused
        send_event(make_event(REQ_WRITE, 8'h81, 8'h7E, 8'd255, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DATA, 8'h00, 8'h00, 8'd0, 8'hAA, 1'b0, 1'b0, 8'h00));
        send_event(make_event(REQ_DONE, 8'h00, 8'h00, 8'd0, 8'h00, 1'b1, 1'b1, 8'h00));
    endtask

    task automatic test_stray_events();
        send_event(make_event(REQ_DONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        send_event(make_event(REQ_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 1'b1, 1'b1, 8'hFF));
    endtask

    // Random walk: mostly the event that the current phase waits for, with
    // random content, plus some fully random events.
    task automatic test_random_traffic();
        int    counted;
        item_t ev;
        counted = 0;
        while (counted < RANDOM_EVENTS)
        begin
            steady = (counted >= 40 && counted < 70);
            ev     = random_event();
            if ($urandom_range(99) < 85)
            begin
                case (seq_phase)
                    PH_IDLE:
                    begin
                        ev.req_type   = $urandom_range(1) ? REQ_READ : REQ_WRITE;
                        ev.byte_count = ($urandom_range(99) < 85) ? 8'($urandom_range(4))
                                                                  : 8'($urandom_range(255));
                    end
                    PH_WREQ:
                        ev.req_type = REQ_DATA;
                    default:
                    begin
                        ev.req_type = REQ_DONE;
                        ev.got_nack = ($urandom_range(99) < 8);
                        ev.arb_lost = ($urandom_range(99) < 25);
                        // keep long transfers from eating the whole run
                        if (bytes_left > 8'd8 && (seq_phase == PH_DEVR ||
                            (seq_phase == PH_WDATA && $urandom_range(1) == 1)))
                            ev.got_nack = 1'b1;
                    end
                endcase
            end
            send_event(ev);
            if (last_produced > 0)
                counted++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        bus_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual kind %0d data 0x%h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_kind", want.kind, m_axis_tuser);
                check_field("cmd_start", want.cmd_start, m_axis_tdata[0]);
                check_field("cmd_write", want.cmd_write, m_axis_tdata[1]);
                check_field("cmd_read", want.cmd_read, m_axis_tdata[2]);
                check_field("cmd_nack", want.cmd_nack, m_axis_tdata[3]);
                check_field("cmd_stop", want.cmd_stop, m_axis_tdata[4]);
                check_field("byte_value", want.byte_value, m_axis_tdata[12:5]);
                check_field("status", want.status, m_axis_tdata[15:13]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 20);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_write_extremes();
        test_read_ack_nack();
        test_zero_count_write();
        test_full_count_aborts();
        test_stray_events();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
